// ===== hw/rtl/cppd_pkg.sv =====
// Package for the camera point projection core: register indexes, distortion
// modes, divider latency, fixed-point helpers and the divider sideband record.
// No dependencies.
`default_nettype none

package cppd_pkg;

  localparam int unsigned DIV_STEPS = 32;
  localparam int unsigned DIV_LAT   = DIV_STEPS + 4;

  localparam logic signed [63:0] Q_ONE = 64'sd16777216;
  localparam logic signed [31:0] S32_MAX = 32'sh7FFFFFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh80000000;

  typedef enum logic [2:0] {
    CFG_CALIBRATED = 3'd0,
    CFG_DIST_MODE  = 3'd1,
    CFG_RAD_COEF   = 3'd2,
    CFG_TAN_COEF   = 3'd3,
    CFG_DEN_COEF   = 3'd4,
    CFG_FOCAL      = 3'd5,
    CFG_PRINCIPAL  = 3'd6
  } cfg_idx_t;

  typedef enum logic [1:0] {
    MODE_NONE = 2'd0,
    MODE_K4   = 2'd1,
    MODE_K5   = 2'd2,
    MODE_K8   = 2'd3
  } dist_mode_t;

  typedef struct packed {
    logic              vld;
    logic              kill;
    logic              den_zero;
    logic signed [31:0] xn;
    logic signed [31:0] yn;
    logic signed [31:0] a1;
    logic signed [31:0] a2;
    logic signed [31:0] a3;
    logic signed [31:0] cd;
  } dly2_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'(S32_MAX)) r = S32_MAX;
    else if (v < 64'(S32_MIN)) r = S32_MIN;
    else r = v[31:0];
    return r;
  endfunction

  // round to nearest, ties away from zero
  function automatic logic signed [63:0] rshr(input logic signed [63:0] v,
                                              input int unsigned s);
    logic signed [63:0] h;
    h = 64'sd1 <<< (s - 1);
    return (v + h - signed'({63'd0, v[63]})) >>> s;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/cppd_div.sv =====
// Pipelined restoring divider: rounded signed (num << 24) / den, saturated to 32 bits.
// Advances only while en is high; depends on cppd_pkg.
`default_nettype none

module cppd_div (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic signed [31:0] num,
  input  wire logic signed [31:0] den,
  output logic signed [31:0]      quo
);

  localparam int unsigned N = cppd_pkg::DIV_STEPS;

  logic [31:0] nm0_r, dm0_r;
  logic        neg0_r;
  logic [55:0] nn1_r;
  logic [31:0] dm1_r;
  logic        neg1_r;

  logic [31:0] rem_r [0:N];
  logic [31:0] low_r [0:N];
  logic [31:0] q_r   [0:N];
  logic [31:0] dm_r  [0:N];
  logic        neg_r [0:N];
  logic        ovf_r [0:N];

  logic signed [31:0] quo_r;
  logic signed [31:0] quo_nxt;

  always_ff @(posedge clk) begin
    if (en) begin
      nm0_r  <= num[31] ? 32'(-num) : num;
      dm0_r  <= den[31] ? 32'(-den) : den;
      neg0_r <= num[31] ^ den[31];
      nn1_r  <= {nm0_r, 24'd0} + {24'd0, dm0_r >> 1};
      dm1_r  <= dm0_r;
      neg1_r <= neg0_r;
      ovf_r[0] <= {8'd0, nn1_r} >= {dm1_r, 32'd0};
      rem_r[0] <= {8'd0, nn1_r[55:32]};
      low_r[0] <= nn1_r[31:0];
      q_r[0]   <= '0;
      dm_r[0]  <= dm1_r;
      neg_r[0] <= neg1_r;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_step
    logic [32:0] trial;
    logic        take;
    assign trial = {rem_r[i], low_r[i][31]};
    assign take  = trial >= {1'b0, dm_r[i]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i+1] <= take ? 32'(trial - {1'b0, dm_r[i]}) : trial[31:0];
        low_r[i+1] <= {low_r[i][30:0], 1'b0};
        q_r[i+1]   <= {q_r[i][30:0], take};
        dm_r[i+1]  <= dm_r[i];
        neg_r[i+1] <= neg_r[i];
        ovf_r[i+1] <= ovf_r[i];
      end
    end
  end

  always_comb begin
    if (neg_r[N]) begin
      if (ovf_r[N] || q_r[N] > 32'h80000000) quo_nxt = cppd_pkg::S32_MIN;
      else quo_nxt = 32'(-q_r[N]);
    end else begin
      if (ovf_r[N] || q_r[N][31]) quo_nxt = cppd_pkg::S32_MAX;
      else quo_nxt = q_r[N];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quo_r <= quo_nxt;
    end
  end

  assign quo = quo_r;

endmodule

`default_nettype wire

// ===== hw/rtl/camera_point_projection_distortion_core.sv =====
// Pinhole projection with Brown-Conrady / rational distortion. One point per cycle
// enters and one result per cycle leaves; the path runs through two 36-stage restoring
// dividers (depth divide, rational denominator divide) in series with the multiply
// stages. The whole pipeline stalls only while a result waits on out_ready. Uses
// cppd_pkg and cppd_div.
`default_nettype none

module camera_point_projection_distortion_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [31:0] in_point_x,
  input  wire logic signed [31:0] in_point_y,
  input  wire logic signed [31:0] in_point_z,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      out_image_x,
  output logic signed [31:0]      out_image_y,
  output logic                    out_visible,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [47:0]        cfg_wdata
);

  localparam int unsigned L = cppd_pkg::DIV_LAT;

  logic                   calibrated_r;
  cppd_pkg::dist_mode_t   dist_mode_r;
  logic [47:0]            rad_coef_r, den_coef_r, focal_r, pp_r;
  logic [31:0]            tan_coef_r;

  logic out_valid_r, out_visible_r;
  logic adv;
  logic mode_ge5, mode_k8;

  assign adv       = !out_valid_r || out_ready;
  assign in_ready  = adv;
  assign cfg_ready = 1'b1;
  assign mode_ge5  = dist_mode_r inside {cppd_pkg::MODE_K5, cppd_pkg::MODE_K8};
  assign mode_k8   = dist_mode_r == cppd_pkg::MODE_K8;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      calibrated_r <= 1'b0;
      dist_mode_r  <= cppd_pkg::MODE_NONE;
      rad_coef_r   <= '0;
      tan_coef_r   <= '0;
      den_coef_r   <= '0;
      focal_r      <= '0;
      pp_r         <= '0;
    end else if (cfg_valid) begin
      case (cppd_pkg::cfg_idx_t'(cfg_index))
        cppd_pkg::CFG_CALIBRATED: calibrated_r <= cfg_wdata[0];
        cppd_pkg::CFG_DIST_MODE:  dist_mode_r  <= cppd_pkg::dist_mode_t'(cfg_wdata[1:0]);
        cppd_pkg::CFG_RAD_COEF:   rad_coef_r   <= cfg_wdata;
        cppd_pkg::CFG_TAN_COEF:   tan_coef_r   <= cfg_wdata[31:0];
        cppd_pkg::CFG_DEN_COEF:   den_coef_r   <= cfg_wdata;
        cppd_pkg::CFG_FOCAL:      focal_r      <= cfg_wdata;
        cppd_pkg::CFG_PRINCIPAL:  pp_r         <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic signed [15:0] k1, k2, k3, k4, k5, k6, p1, p2;
  assign k1 = signed'(rad_coef_r[15:0]);
  assign k2 = signed'(rad_coef_r[31:16]);
  assign k3 = signed'(rad_coef_r[47:32]);
  assign k4 = signed'(den_coef_r[15:0]);
  assign k5 = signed'(den_coef_r[31:16]);
  assign k6 = signed'(den_coef_r[47:32]);
  assign p1 = signed'(tan_coef_r[15:0]);
  assign p2 = signed'(tan_coef_r[31:16]);

  // depth divide
  logic signed [31:0] xn_q, yn_q;
  logic               vld1_r  [L];
  logic               kill1_r [L];
  logic               kill_in;

  assign kill_in = !calibrated_r || in_point_z[31] || in_point_z == 32'sd0;

  cppd_div u_div_x (.clk(clk), .en(adv), .num(in_point_x), .den(in_point_z), .quo(xn_q));
  cppd_div u_div_y (.clk(clk), .en(adv), .num(in_point_y), .den(in_point_z), .quo(yn_q));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < L; i++) vld1_r[i] <= 1'b0;
    end else if (adv) begin
      vld1_r[0] <= in_valid;
      for (int i = 1; i < L; i++) vld1_r[i] <= vld1_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      kill1_r[0] <= kill_in;
      for (int i = 1; i < L; i++) kill1_r[i] <= kill1_r[i-1];
    end
  end

  // distortion polynomial stages
  logic p1_vld_r, p2_vld_r, p3_vld_r, p4_vld_r, p5_vld_r;
  logic p6_vld_r, p7_vld_r, p8_vld_r, p9_vld_r, p10_vld_r;
  logic p1_kill_r, p2_kill_r, p3_kill_r, p4_kill_r, p5_kill_r;
  logic p6_kill_r, p7_kill_r, p8_kill_r, p9_kill_r, p10_kill_r;

  logic signed [31:0] p1_xn_r, p1_yn_r;
  logic signed [63:0] p1_xx_r, p1_yy_r, p1_xy_r;
  logic signed [31:0] p2_xn_r, p2_yn_r, p2_x2_r, p2_y2_r, p2_xy_r;
  logic signed [31:0] p3_xn_r, p3_yn_r, p3_x2_r, p3_y2_r, p3_r2_r, p3_a1_r;
  logic signed [31:0] p4_xn_r, p4_yn_r, p4_r2_r, p4_a1_r, p4_a2_r, p4_a3_r;
  logic signed [63:0] p4_pr4_r;
  logic signed [31:0] p5_xn_r, p5_yn_r, p5_r2_r, p5_a1_r, p5_a2_r, p5_a3_r, p5_r4_r;
  logic signed [31:0] p6_xn_r, p6_yn_r, p6_a1_r, p6_a2_r, p6_a3_r;
  logic signed [63:0] p6_pr6_r;
  logic signed [47:0] p6_k1r2_r, p6_k2r4_r, p6_k4r2_r, p6_k5r4_r;
  logic signed [31:0] p7_xn_r, p7_yn_r, p7_a1_r, p7_a2_r, p7_a3_r, p7_r6_r;
  logic signed [39:0] p7_t1_r, p7_t2_r, p7_d1_r, p7_d2_r;
  logic signed [31:0] p8_xn_r, p8_yn_r, p8_a1_r, p8_a2_r, p8_a3_r;
  logic signed [39:0] p8_t1_r, p8_t2_r, p8_d1_r, p8_d2_r;
  logic signed [47:0] p8_k3r6_r, p8_k6r6_r;
  logic signed [31:0] p9_xn_r, p9_yn_r, p9_a1_r, p9_a2_r, p9_a3_r, p9_cd0_r;
  logic signed [39:0] p9_t3_r, p9_d1_r, p9_d2_r, p9_d3_r;
  logic signed [31:0] p10_xn_r, p10_yn_r, p10_a1_r, p10_a2_r, p10_a3_r;
  logic signed [31:0] p10_cd_r, p10_den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0; p2_vld_r <= 1'b0; p3_vld_r <= 1'b0; p4_vld_r <= 1'b0;
      p5_vld_r <= 1'b0; p6_vld_r <= 1'b0; p7_vld_r <= 1'b0; p8_vld_r <= 1'b0;
      p9_vld_r <= 1'b0; p10_vld_r <= 1'b0;
    end else if (adv) begin
      p1_vld_r <= vld1_r[L-1];
      p2_vld_r <= p1_vld_r; p3_vld_r <= p2_vld_r; p4_vld_r <= p3_vld_r;
      p5_vld_r <= p4_vld_r; p6_vld_r <= p5_vld_r; p7_vld_r <= p6_vld_r;
      p8_vld_r <= p7_vld_r; p9_vld_r <= p8_vld_r; p10_vld_r <= p9_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_kill_r <= kill1_r[L-1];
      p2_kill_r <= p1_kill_r; p3_kill_r <= p2_kill_r; p4_kill_r <= p3_kill_r;
      p5_kill_r <= p4_kill_r; p6_kill_r <= p5_kill_r; p7_kill_r <= p6_kill_r;
      p8_kill_r <= p7_kill_r; p9_kill_r <= p8_kill_r; p10_kill_r <= p9_kill_r;

      p1_xn_r <= xn_q;
      p1_yn_r <= yn_q;
      p1_xx_r <= xn_q * xn_q;
      p1_yy_r <= yn_q * yn_q;
      p1_xy_r <= xn_q * yn_q;

      p2_xn_r <= p1_xn_r;
      p2_yn_r <= p1_yn_r;
      p2_x2_r <= cppd_pkg::sat32(cppd_pkg::rshr(p1_xx_r, 24));
      p2_y2_r <= cppd_pkg::sat32(cppd_pkg::rshr(p1_yy_r, 24));
      p2_xy_r <= cppd_pkg::sat32(cppd_pkg::rshr(p1_xy_r, 24));

      p3_xn_r <= p2_xn_r;
      p3_yn_r <= p2_yn_r;
      p3_x2_r <= p2_x2_r;
      p3_y2_r <= p2_y2_r;
      p3_r2_r <= cppd_pkg::sat32(64'(p2_x2_r) + 64'(p2_y2_r));
      p3_a1_r <= cppd_pkg::sat32(64'(p2_xy_r) <<< 1);

      p4_xn_r  <= p3_xn_r;
      p4_yn_r  <= p3_yn_r;
      p4_r2_r  <= p3_r2_r;
      p4_a1_r  <= p3_a1_r;
      p4_a2_r  <= cppd_pkg::sat32(64'(p3_r2_r) + (64'(p3_x2_r) <<< 1));
      p4_a3_r  <= cppd_pkg::sat32(64'(p3_r2_r) + (64'(p3_y2_r) <<< 1));
      p4_pr4_r <= p3_r2_r * p3_r2_r;

      p5_xn_r <= p4_xn_r;
      p5_yn_r <= p4_yn_r;
      p5_r2_r <= p4_r2_r;
      p5_a1_r <= p4_a1_r;
      p5_a2_r <= p4_a2_r;
      p5_a3_r <= p4_a3_r;
      p5_r4_r <= cppd_pkg::sat32(cppd_pkg::rshr(p4_pr4_r, 24));

      p6_xn_r   <= p5_xn_r;
      p6_yn_r   <= p5_yn_r;
      p6_a1_r   <= p5_a1_r;
      p6_a2_r   <= p5_a2_r;
      p6_a3_r   <= p5_a3_r;
      p6_pr6_r  <= p5_r4_r * p5_r2_r;
      p6_k1r2_r <= k1 * p5_r2_r;
      p6_k2r4_r <= k2 * p5_r4_r;
      p6_k4r2_r <= k4 * p5_r2_r;
      p6_k5r4_r <= k5 * p5_r4_r;

      p7_xn_r <= p6_xn_r;
      p7_yn_r <= p6_yn_r;
      p7_a1_r <= p6_a1_r;
      p7_a2_r <= p6_a2_r;
      p7_a3_r <= p6_a3_r;
      p7_r6_r <= cppd_pkg::sat32(cppd_pkg::rshr(p6_pr6_r, 24));
      p7_t1_r <= 40'(cppd_pkg::rshr(64'(p6_k1r2_r), 12));
      p7_t2_r <= 40'(cppd_pkg::rshr(64'(p6_k2r4_r), 12));
      p7_d1_r <= 40'(cppd_pkg::rshr(64'(p6_k4r2_r), 12));
      p7_d2_r <= 40'(cppd_pkg::rshr(64'(p6_k5r4_r), 12));

      p8_xn_r   <= p7_xn_r;
      p8_yn_r   <= p7_yn_r;
      p8_a1_r   <= p7_a1_r;
      p8_a2_r   <= p7_a2_r;
      p8_a3_r   <= p7_a3_r;
      p8_t1_r   <= p7_t1_r;
      p8_t2_r   <= p7_t2_r;
      p8_d1_r   <= p7_d1_r;
      p8_d2_r   <= p7_d2_r;
      p8_k3r6_r <= k3 * p7_r6_r;
      p8_k6r6_r <= k6 * p7_r6_r;

      p9_xn_r  <= p8_xn_r;
      p9_yn_r  <= p8_yn_r;
      p9_a1_r  <= p8_a1_r;
      p9_a2_r  <= p8_a2_r;
      p9_a3_r  <= p8_a3_r;
      p9_cd0_r <= cppd_pkg::sat32(cppd_pkg::Q_ONE + 64'(p8_t1_r) + 64'(p8_t2_r));
      p9_t3_r  <= 40'(cppd_pkg::rshr(64'(p8_k3r6_r), 12));
      p9_d1_r  <= p8_d1_r;
      p9_d2_r  <= p8_d2_r;
      p9_d3_r  <= 40'(cppd_pkg::rshr(64'(p8_k6r6_r), 12));

      p10_xn_r  <= p9_xn_r;
      p10_yn_r  <= p9_yn_r;
      p10_a1_r  <= p9_a1_r;
      p10_a2_r  <= p9_a2_r;
      p10_a3_r  <= p9_a3_r;
      p10_cd_r  <= mode_ge5 ? cppd_pkg::sat32(64'(p9_cd0_r) + 64'(p9_t3_r)) : p9_cd0_r;
      p10_den_r <= cppd_pkg::sat32(cppd_pkg::Q_ONE + 64'(p9_d1_r) + 64'(p9_d2_r)
                                   + 64'(p9_d3_r));
    end
  end

  // rational divide
  logic signed [31:0] cdq;
  cppd_pkg::dly2_t    d2_r [L];
  cppd_pkg::dly2_t    d2_in;

  assign d2_in = '{vld: p10_vld_r, kill: p10_kill_r, den_zero: p10_den_r == 32'sd0,
                   xn: p10_xn_r, yn: p10_yn_r, a1: p10_a1_r, a2: p10_a2_r,
                   a3: p10_a3_r, cd: p10_cd_r};

  cppd_div u_div_cd (.clk(clk), .en(adv), .num(p10_cd_r), .den(p10_den_r), .quo(cdq));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < L; i++) d2_r[i].vld <= 1'b0;
    end else if (adv) begin
      d2_r[0] <= d2_in;
      for (int i = 1; i < L; i++) d2_r[i] <= d2_r[i-1];
    end
  end

  // correction and projection
  cppd_pkg::dly2_t    dq;
  logic signed [31:0] cdf;
  assign dq = d2_r[L-1];

  always_comb begin
    if (!mode_k8) cdf = dq.cd;
    else if (!dq.den_zero) cdf = cdq;
    else if (dq.cd > 32'sd0) cdf = cppd_pkg::S32_MAX;
    else if (dq.cd < 32'sd0) cdf = cppd_pkg::S32_MIN;
    else cdf = 32'sd0;
  end

  logic               q1_vld_r, q2_vld_r, q3_vld_r;
  logic               q1_kill_r, q2_kill_r, q3_kill_r;
  logic signed [31:0] q1_xn_r, q1_yn_r;
  logic signed [63:0] q1_xc_r, q1_yc_r;
  logic signed [47:0] q1_p1a1_r, q1_p2a2_r, q1_p1a3_r, q1_p2a1_r;
  logic signed [31:0] q2_xd_r, q2_yd_r;
  logic signed [56:0] q3_fx_r, q3_fy_r;
  logic signed [31:0] out_image_x_r, out_image_y_r;
  logic signed [31:0] img_x_nxt, img_y_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q1_vld_r    <= 1'b0;
      q2_vld_r    <= 1'b0;
      q3_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      q1_vld_r    <= dq.vld;
      q2_vld_r    <= q1_vld_r;
      q3_vld_r    <= q2_vld_r;
      out_valid_r <= q3_vld_r;
    end
  end

  assign img_x_nxt = cppd_pkg::sat32(cppd_pkg::rshr(64'(q3_fx_r), 20)
                                     + signed'(64'({pp_r[23:0], 4'd0})));
  assign img_y_nxt = cppd_pkg::sat32(cppd_pkg::rshr(64'(q3_fy_r), 20)
                                     + signed'(64'({pp_r[47:24], 4'd0})));

  always_ff @(posedge clk) begin
    if (adv) begin
      q1_kill_r <= dq.kill;
      q1_xn_r   <= dq.xn;
      q1_yn_r   <= dq.yn;
      q1_xc_r   <= dq.xn * cdf;
      q1_yc_r   <= dq.yn * cdf;
      q1_p1a1_r <= p1 * dq.a1;
      q1_p2a2_r <= p2 * dq.a2;
      q1_p1a3_r <= p1 * dq.a3;
      q1_p2a1_r <= p2 * dq.a1;

      q2_kill_r <= q1_kill_r;
      if (dist_mode_r == cppd_pkg::MODE_NONE) begin
        q2_xd_r <= q1_xn_r;
        q2_yd_r <= q1_yn_r;
      end else begin
        q2_xd_r <= cppd_pkg::sat32(cppd_pkg::rshr(q1_xc_r, 24)
                                   + cppd_pkg::rshr(64'(q1_p1a1_r), 12)
                                   + cppd_pkg::rshr(64'(q1_p2a2_r), 12));
        q2_yd_r <= cppd_pkg::sat32(cppd_pkg::rshr(q1_yc_r, 24)
                                   + cppd_pkg::rshr(64'(q1_p1a3_r), 12)
                                   + cppd_pkg::rshr(64'(q1_p2a1_r), 12));
      end

      q3_kill_r <= q2_kill_r;
      q3_fx_r   <= q2_xd_r * signed'({1'b0, focal_r[23:0]});
      q3_fy_r   <= q2_yd_r * signed'({1'b0, focal_r[47:24]});

      out_visible_r <= !q3_kill_r;
      out_image_x_r <= q3_kill_r ? 32'sd0 : img_x_nxt;
      out_image_y_r <= q3_kill_r ? 32'sd0 : img_y_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_visible = out_visible_r;
  assign out_image_x = out_image_x_r;
  assign out_image_y = out_image_y_r;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid_r)
    else $error("result valid right after reset");

  a_invisible_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_visible_r |-> out_image_x_r == 32'sd0 && out_image_y_r == 32'sd0)
    else $error("invisible result with nonzero coordinates");

  a_visible_calib: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_visible_r |-> calibrated_r)
    else $error("visible result while not calibrated");

  a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(p10_vld_r) && $stable(q3_vld_r) && $stable(p10_cd_r))
    else $error("pipeline moved during a stall");

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// Self-checking testbench for camera_point_projection_distortion_core: drives points and
// register writes over valid/ready channels and checks projections against a fixed-point model.
// Depends on cppd_pkg and the core RTL.
`default_nettype none

typedef struct {
  logic signed [31:0] ix;
  logic signed [31:0] iy;
  logic               vis;
} proj_t;

class proj_scoreboard;
  logic        calibrated;
  logic [1:0]  mode;
  logic [47:0] rad, tang, den, focal, pp;
  proj_t       pending_q[$];
  int          mismatches;
  int          checked;

  function new();
    calibrated = 0; mode = 0; rad = 0; tang = 0; den = 0; focal = 0; pp = 0;
    mismatches = 0; checked = 0;
  endfunction

  function void set_reg(cppd_pkg::cfg_idx_t idx, logic [47:0] v);
    case (idx)
      cppd_pkg::CFG_CALIBRATED: calibrated = v[0];
      cppd_pkg::CFG_DIST_MODE:  mode = v[1:0];
      cppd_pkg::CFG_RAD_COEF:   rad = v;
      cppd_pkg::CFG_TAN_COEF:   tang = {16'd0, v[31:0]};
      cppd_pkg::CFG_DEN_COEF:   den = v;
      cppd_pkg::CFG_FOCAL:      focal = v;
      cppd_pkg::CFG_PRINCIPAL:  pp = v;
      default: ;
    endcase
  endfunction

  function longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function longint round_shr(longint v, int s);
    longint m;
    m = (v < 0) ? -v : v;
    m = (m + (64'sd1 <<< (s - 1))) >>> s;
    return (v < 0) ? -m : m;
  endfunction

  function longint round_div(longint n, longint d);
    longint nm, dm, q;
    nm = (n < 0) ? -n : n;
    dm = (d < 0) ? -d : d;
    q = ((nm <<< 24) + dm / 2) / dm;
    return ((n < 0) != (d < 0)) ? -q : q;
  endfunction

  function longint qmul(longint a, longint b);
    return clip32(round_shr(a * b, 24));
  endfunction

  function longint slot16(logic [47:0] r, int s);
    logic signed [15:0] c;
    c = r[16*s +: 16];
    return longint'(c);
  endfunction

  function longint cterm(longint c, longint v);
    return round_shr(c * v, 12);
  endfunction

  function longint to_pixels(longint nv, int s);
    longint f, c;
    f = longint'(focal[24*s +: 24]);
    c = longint'(pp[24*s +: 24]);
    return clip32(round_shr(nv * f, 20) + c * 16);
  endfunction

  function proj_t project_point(int px, int py, int pz);
    proj_t  r;
    longint xn, yn, xd, yd, x2, y2, r2, r4, r6, a1, a2, a3, cd, dv, p1, p2;
    r.ix = 0; r.iy = 0; r.vis = 0;
    if (!calibrated || pz <= 0) return r;
    xn = clip32(round_div(px, pz));
    yn = clip32(round_div(py, pz));
    xd = xn;
    yd = yn;
    if (mode != cppd_pkg::MODE_NONE) begin
      x2 = qmul(xn, xn);
      y2 = qmul(yn, yn);
      r2 = clip32(x2 + y2);
      r4 = qmul(r2, r2);
      a1 = clip32(2 * qmul(xn, yn));
      a2 = clip32(r2 + 2 * x2);
      a3 = clip32(r2 + 2 * y2);
      p1 = slot16(tang, 0);
      p2 = slot16(tang, 1);
      cd = clip32((64'sd1 <<< 24) + cterm(slot16(rad, 0), r2) + cterm(slot16(rad, 1), r4));
      if (mode >= cppd_pkg::MODE_K5) begin
        r6 = qmul(r4, r2);
        cd = clip32(cd + cterm(slot16(rad, 2), r6));
        if (mode == cppd_pkg::MODE_K8) begin
          dv = clip32((64'sd1 <<< 24) + cterm(slot16(den, 0), r2)
                      + cterm(slot16(den, 1), r4) + cterm(slot16(den, 2), r6));
          if (dv == 0)
            cd = (cd > 0) ? 64'sd2147483647 : ((cd < 0) ? -64'sd2147483648 : 0);
          else
            cd = clip32(round_div(cd, dv));
        end
      end
      xd = clip32(round_shr(xn * cd, 24) + cterm(p1, a1) + cterm(p2, a2));
      yd = clip32(round_shr(yn * cd, 24) + cterm(p1, a3) + cterm(p2, a1));
    end
    r.ix = 32'(to_pixels(xd, 0));
    r.iy = 32'(to_pixels(yd, 1));
    r.vis = 1;
    return r;
  endfunction

  function void note_point(int px, int py, int pz);
    pending_q.push_back(project_point(px, py, pz));
  endfunction

  function void check_result(logic signed [31:0] ix, logic signed [31:0] iy, logic vis);
    proj_t e;
    checked++;
    if (pending_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result x=%h y=%h vis=%b", ix, iy, vis);
      return;
    end
    e = pending_q.pop_front();
    if (e.ix !== ix || e.iy !== iy || e.vis !== vis) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: expected x=%h y=%h vis=%b, got x=%h y=%h vis=%b",
                 e.ix, e.iy, e.vis, ix, iy, vis);
    end
  endfunction

  function int pending();
    return pending_q.size();
  endfunction
endclass

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic               clk, rst_n;
  logic               in_valid, in_ready;
  logic signed [31:0] in_point_x, in_point_y, in_point_z;
  logic               out_valid, out_ready;
  logic signed [31:0] out_image_x, out_image_y;
  logic               out_visible;
  logic               cfg_valid, cfg_ready;
  logic [2:0]         cfg_index;
  logic [47:0]        cfg_wdata;

  proj_scoreboard sb = new();
  bit hold_req;
  int points_sent;

  camera_point_projection_distortion_core u_top (.*);

  always begin
    clk = 1'b1; #4;
    clk = 1'b0; #4;
  end

  initial begin
    #3000000;
    $display("FAIL camera_point_projection_distortion_core");
    $finish;
  end

  // result acceptance: outputs and ready are stable at the falling edge
  always @(negedge clk)
    if (rst_n && out_valid && out_ready) sb.check_result(out_image_x, out_image_y, out_visible);

  initial begin
    int style;
    int n;
    out_ready = 1'b0;
    hold_req = 0;
    style = 0;
    n = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_req = 0;
      end
      if (n % 64 == 0) style = $urandom_range(0, 2);
      n++;
      case (style)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 3) != 0);
        default: out_ready <= (n % 5 < 2);
      endcase
    end
  end

  task automatic cfg_write(cppd_pkg::cfg_idx_t idx, logic [47:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    sb.set_reg(idx, v);
  endtask

  task automatic set_all(logic cal, cppd_pkg::dist_mode_t m, logic [47:0] rad,
                         logic [47:0] tang, logic [47:0] den, logic [47:0] foc,
                         logic [47:0] pp);
    cfg_write(cppd_pkg::CFG_CALIBRATED, {47'd0, cal});
    cfg_write(cppd_pkg::CFG_DIST_MODE, {46'd0, m});
    cfg_write(cppd_pkg::CFG_RAD_COEF, rad);
    cfg_write(cppd_pkg::CFG_TAN_COEF, tang);
    cfg_write(cppd_pkg::CFG_DEN_COEF, den);
    cfg_write(cppd_pkg::CFG_FOCAL, foc);
    cfg_write(cppd_pkg::CFG_PRINCIPAL, pp);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_point(int px, int py, int pz);
    in_valid <= 1'b1;
    in_point_x <= px;
    in_point_y <= py;
    in_point_z <= pz;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    sb.note_point(px, py, pz);
    points_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (cppd_pkg::DIV_LAT * 3) @(posedge clk);
  endtask

  function automatic logic [47:0] mild_coeffs();
    logic [47:0] r;
    for (int s = 0; s < 3; s++) r[16*s +: 16] = 16'($signed($urandom_range(0, 4095)) - 2048);
    return r;
  endfunction

  function automatic logic [47:0] rand48();
    return 48'({$urandom, $urandom});
  endfunction

  task automatic send_batch(int n, bit wild, bit no_gaps);
    int i, burst, px, py, pz;
    i = 0;
    while (i < n) begin
      burst = $urandom_range(1, 24);
      repeat (burst) if (i < n) begin
        if (wild || $urandom_range(0, 9) == 0) begin
          px = $urandom; py = $urandom; pz = $urandom;
        end else begin
          pz = $urandom_range(4096, 1 << 22);
          px = int'($urandom_range(0, 4 * pz)) - 2 * pz;
          py = int'($urandom_range(0, 4 * pz)) - 2 * pz;
          if ($urandom_range(0, 15) == 0) pz = -pz;
        end
        send_point(px, py, pz);
        i++;
      end
      if (!no_gaps && i < n && $urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  endtask

  initial begin
    logic [47:0] foc, pp;
    in_valid = 0; in_point_x = 0; in_point_y = 0; in_point_z = 0;
    cfg_valid = 0; cfg_index = 0; cfg_wdata = 0;
    points_sent = 0;
    rst_n = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // uncalibrated after reset
    send_point(1 << 16, 1 << 16, 1 << 16);
    send_point(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
    send_point(-5, 7, 0);
    drain();

    foc = {24'd600 << 12, 24'd500 << 12};
    pp = {24'd240 << 12, 24'd320 << 12};
    set_all(1'b1, cppd_pkg::MODE_NONE, 48'd0, 48'd0, 48'd0, foc, pp);
    send_point(0, 0, 1 << 16);
    send_point(32'h7FFFFFFF, 32'h7FFFFFFF, 1);
    send_point(32'h80000000, 32'h80000000, 1);
    send_point(3 << 16, -2 << 16, 0);
    send_point(3 << 16, -2 << 16, -1);
    send_point(3 << 16, -2 << 16, 32'h80000000);
    send_point(1, -1, 32'h7FFFFFFF);
    send_point(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
    drain();

    set_all(1'b1, cppd_pkg::MODE_K4, mild_coeffs(), {16'd0, 16'($signed(-300)), 16'd200},
            48'd0, foc, pp);
    send_point(32'h7FFFFFFF, 32'h80000000, 1);
    send_batch(120, 0, 0);
    drain();

    set_all(1'b1, cppd_pkg::MODE_K5, mild_coeffs(), mild_coeffs(), 48'd0, foc, pp);
    send_batch(120, 0, 0);
    drain();

    // zero rational denominator with positive, zero and negative numerator
    for (int k = 0; k < 3; k++) begin
      set_all(1'b1, cppd_pkg::MODE_K8, {32'd0, 16'($signed(-4096 * k))}, 48'd0,
              {32'd0, 16'($signed(-4096))}, foc, pp);
      send_point(1 << 16, 0, 1 << 16);
      send_point(0, -(1 << 16), 1 << 16);
      send_batch(10, 0, 0);
      drain();
    end

    set_all(1'b1, cppd_pkg::MODE_K8, {48{1'b1}}, {48{1'b1}}, {48{1'b1}}, {48{1'b1}},
            {48{1'b1}});
    send_batch(150, 1, 0);
    drain();

    for (int m = 0; m < 4; m++) begin
      set_all(1'b1, cppd_pkg::dist_mode_t'(m), mild_coeffs(), mild_coeffs(), mild_coeffs(),
              rand48(), rand48());
      if (m == 2) begin
        hold_req = 1;
        send_batch(150, 0, 1);
      end
      send_batch(50, 0, 0);
      send_batch(30, 1, 0);
      drain();
    end

    set_all(1'b1, cppd_pkg::MODE_K8, rand48(), rand48(), rand48(), rand48(), rand48());
    send_batch(60, 1, 0);
    drain();

    set_all(1'b0, cppd_pkg::MODE_K4, mild_coeffs(), mild_coeffs(), 48'd0, foc, pp);
    send_batch(30, 1, 0);
    drain();

    $display("covered %0d points, %0d results checked, over all distortion modes,", points_sent,
             sb.checked);
    $display("uncalibrated and extreme register settings, long output stalls");
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("PASS camera_point_projection_distortion_core");
    else
      $display("FAIL camera_point_projection_distortion_core");
    $finish;
  end
endmodule

`default_nettype wire
